FILE: rtl/core/vt4_pkg.sv
`timescale 1ns / 1ps
package vt4_pkg;

   // Fixed field widths and the default fixed-point position
   localparam int COORD_W       = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int SUM_W         = 66;
   localparam int REQ_DATA_W    = 136;
   localparam int RSP_DATA_W    = 128;
   localparam int RSP_USER_W    = 2;
   localparam int TAG_W         = 4 * COORD_W + 1;

   // Input item kinds
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_XFORM = 1'b1;

   // Output modes
   localparam logic MODE_CART  = 1'b0;
   localparam logic MODE_HOMOG = 1'b1;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

FILE: rtl/core/vt4_div.sv
`timescale 1ns / 1ps
module vt4_div #(
   parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF,
   parameter int TAG_BITS  = vt4_pkg::TAG_W
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_vld,
   input  logic [vt4_pkg::COORD_W+FRAC_BITS-1:0]    in_num [3],
   input  logic [vt4_pkg::COORD_W-1:0]              in_den,
   input  logic [TAG_BITS-1:0]                      in_tag,
   output logic                                     out_vld,
   output logic [vt4_pkg::COORD_W+FRAC_BITS-1:0]    out_quo [3],
   output logic [TAG_BITS-1:0]                      out_tag
);
   import vt4_pkg::*;

   localparam int QW = COORD_W + FRAC_BITS;

   logic [QW-1:0]      vld_ff;
   logic [COORD_W-1:0] rem_ff [QW][3];
   logic [QW-1:0]      nq_ff  [QW][3];
   logic [COORD_W-1:0] den_ff [QW];
   logic [TAG_BITS-1:0] tag_ff [QW];

   logic [QW-1:0]      src_vld;
   logic [COORD_W-1:0] src_rem [QW][3];
   logic [QW-1:0]      src_nq  [QW][3];
   logic [COORD_W-1:0] src_den [QW];
   logic [TAG_BITS-1:0] src_tag [QW];
   logic [COORD_W-1:0] rem_in  [QW][3];
   logic [QW-1:0]      nq_in   [QW][3];

   // Pick each stage's source: ports for the first, previous stage otherwise
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            src_vld[k] = in_vld;
            src_den[k] = in_den;
            src_tag[k] = in_tag;
            for (int l = 0; l < 3; l++) begin
               src_rem[k][l] = '0;
               src_nq[k][l]  = in_num[l];
            end
         end else begin
            src_vld[k] = vld_ff[k-1];
            src_den[k] = den_ff[k-1];
            src_tag[k] = tag_ff[k-1];
            for (int l = 0; l < 3; l++) begin
               src_rem[k][l] = rem_ff[k-1][l];
               src_nq[k][l]  = nq_ff[k-1][l];
            end
         end
      end
   end

   // One restoring step per stage: shift in a numerator bit, try subtract
   always_comb begin
      logic [COORD_W:0] shifted;
      logic [COORD_W:0] diff;
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < 3; l++) begin
            shifted = {src_rem[k][l], src_nq[k][l][QW-1]};
            diff    = shifted - {1'b0, src_den[k]};
            if (diff[COORD_W]) begin
               rem_in[k][l] = shifted[COORD_W-1:0];
            end else begin
               rem_in[k][l] = diff[COORD_W-1:0];
            end
            nq_in[k][l] = {src_nq[k][l][QW-2:0], ~diff[COORD_W]};
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= src_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            den_ff[k] <= src_den[k];
            tag_ff[k] <= src_tag[k];
            for (int l = 0; l < 3; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               nq_ff[k][l]  <= nq_in[k][l];
            end
         end
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_tag = tag_ff[QW-1];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_quo[l] = nq_ff[QW-1][l];
      end
   end

endmodule

FILE: rtl/core/vertex_transform_4x4.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 vertex transform in signed fixed point (FRAC_BITS fraction
// bits, Q16.16 by default). Coefficient loads (tuser 0) write the matrix
// at once and return nothing; point items (tuser 1) return one result each,
// in order. The block takes one item every cycle while the skid register is
// empty. A point passes these stages: four form and round the dot products,
// one prepares magnitudes, a fully pipelined restoring divider spends one
// stage per quotient bit (32 + FRAC_BITS of them), one stage applies sign
// and saturation, then the output register. A skid register behind the
// pipeline lets one more item in while a result waits on rsp_tready.
// Write output_mode (csr_data, 0 cartesian, 1 homogeneous) only while idle.
module vertex_transform_4x4 #(
   parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coef_index, coef_value, point_x, point_y, point_z (low bit up), zero pad
   input  logic [vt4_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, out_w (low bit up)
   output logic [vt4_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // divide_by_zero, overflow (low bit up)
   output logic [vt4_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_data
);
   import vt4_pkg::*;

   localparam int QW = COORD_W + FRAC_BITS;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(S32_MAX);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(S32_MIN);
   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);
   localparam coord_type ONE    = coord_type'(COORD_W'(1) << FRAC_BITS);
   localparam coord_type C_MAX  = coord_type'(S32_MAX);
   localparam coord_type C_MIN  = coord_type'(S32_MIN);

   logic       en;
   logic       acc;
   logic       mode_ff;
   logic       skid_vld_ff;
   coord_type  mtx_ff [16];

   logic [3:0] in_idx;
   coord_type  in_coef;
   coord_type  in_pt [3];

   assign in_idx   = req_tdata[3:0];
   assign in_coef  = req_tdata[35:4];
   assign in_pt[0] = req_tdata[67:36];
   assign in_pt[1] = req_tdata[99:68];
   assign in_pt[2] = req_tdata[131:100];

   assign en         = ~skid_vld_ff;
   assign req_tready = en;
   assign acc        = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CART;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // Matrix store: written on a load transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mtx_ff[i] <= (i % 5 == 0) ? ONE : '0;
         end
      end else if (acc && req_tuser == CMD_LOAD) begin
         mtx_ff[in_idx] <= in_coef;
      end
   end

   // Stage A: products with the matrix as of the transfer
   logic                    a_vld_ff;
   logic signed [63:0]      a_prod_ff [4][3];
   coord_type               a_trans_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= acc & (req_tuser == CMD_XFORM);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            a_trans_ff[r] <= mtx_ff[r*4+3];
            for (int c = 0; c < 3; c++) begin
               a_prod_ff[r][c] <= mtx_ff[r*4+c] * in_pt[c];
            end
         end
      end
   end

   // Stage B: partial sums, translation and rounding half folded in
   logic                    b_vld_ff;
   logic signed [SUM_W-1:0] b_s01_ff [4];
   logic signed [SUM_W-1:0] b_s2t_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            b_s01_ff[r] <= SUM_W'(a_prod_ff[r][0]) + SUM_W'(a_prod_ff[r][1]);
            b_s2t_ff[r] <= SUM_W'(a_prod_ff[r][2])
                         + ((SUM_W'(a_trans_ff[r]) <<< FRAC_BITS) | HALF);
         end
      end
   end

   // Stage C: full row sum
   logic                    c_vld_ff;
   logic signed [SUM_W-1:0] c_sum_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            c_sum_ff[r] <= b_s01_ff[r] + b_s2t_ff[r];
         end
      end
   end

   // Stage D: drop fraction bits and saturate to 32 bits
   logic       d_vld_ff;
   coord_type  d_v_ff [4];
   logic       d_ovf_ff;
   coord_type  d_v_in [4];
   logic       d_ovf_in;

   always_comb begin
      logic signed [SUM_W-1:0] sh;
      d_ovf_in = 1'b0;
      for (int r = 0; r < 4; r++) begin
         sh = c_sum_ff[r] >>> FRAC_BITS;
         if (sh > SAT_MAX) begin
            d_v_in[r] = C_MAX;
            d_ovf_in  = 1'b1;
         end else if (sh < SAT_MIN) begin
            d_v_in[r] = C_MIN;
            d_ovf_in  = 1'b1;
         end else begin
            d_v_in[r] = sh[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_v_ff   <= d_v_in;
         d_ovf_ff <= d_ovf_in;
      end
   end

   // Stage E: magnitudes for the divider
   logic               e_vld_ff;
   logic [QW-1:0]      e_num_ff [3];
   logic [COORD_W-1:0] e_den_ff;
   logic [TAG_W-1:0]   e_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            e_num_ff[l] <= {(d_v_ff[l][COORD_W-1] ? COORD_W'(-d_v_ff[l]) : d_v_ff[l]),
                            FRAC_BITS'(0)};
         end
         e_den_ff <= d_v_ff[3][COORD_W-1] ? COORD_W'(-d_v_ff[3]) : d_v_ff[3];
         e_tag_ff <= {d_ovf_ff, d_v_ff[3], d_v_ff[2], d_v_ff[1], d_v_ff[0]};
      end
   end

   // Divider pipeline
   logic               q_vld;
   logic [QW-1:0]      q_quo [3];
   logic [TAG_W-1:0]   q_tag;

   vt4_div #(
      .FRAC_BITS (FRAC_BITS),
      .TAG_BITS  (TAG_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (e_vld_ff),
      .in_num  (e_num_ff),
      .in_den  (e_den_ff),
      .in_tag  (e_tag_ff),
      .out_vld (q_vld),
      .out_quo (q_quo),
      .out_tag (q_tag)
   );

   // Stage G: sign, saturation, zero w and mode select
   coord_type  q_v [4];
   logic       q_ovf;
   logic       g_vld_ff;
   coord_type  g_res_ff [4];
   logic       g_dz_ff;
   logic       g_ovf_ff;
   coord_type  g_res_in [4];
   logic       g_dz_in;
   logic       g_ovf_in;

   assign q_v[0] = q_tag[31:0];
   assign q_v[1] = q_tag[63:32];
   assign q_v[2] = q_tag[95:64];
   assign q_v[3] = q_tag[127:96];
   assign q_ovf  = q_tag[128];

   always_comb begin
      logic neg;
      g_res_in[3] = q_v[3];
      g_ovf_in    = q_ovf;
      g_dz_in     = 1'b0;
      for (int l = 0; l < 3; l++) begin
         neg = q_v[l][COORD_W-1] ^ q_v[3][COORD_W-1];
         if (mode_ff == MODE_HOMOG) begin
            g_res_in[l] = q_v[l];
         end else if (q_v[3] == '0) begin
            g_dz_in = 1'b1;
            if (q_v[l][COORD_W-1]) begin
               g_res_in[l] = C_MIN;
            end else if (q_v[l] != '0) begin
               g_res_in[l] = C_MAX;
            end else begin
               g_res_in[l] = '0;
            end
         end else if (!neg) begin
            if (|q_quo[l][QW-1:COORD_W-1]) begin
               g_res_in[l] = C_MAX;
               g_ovf_in    = 1'b1;
            end else begin
               g_res_in[l] = q_quo[l][COORD_W-1:0];
            end
         end else begin
            if ((|q_quo[l][QW-1:COORD_W]) ||
                (q_quo[l][COORD_W-1] && (|q_quo[l][COORD_W-2:0]))) begin
               g_res_in[l] = C_MIN;
               g_ovf_in    = 1'b1;
            end else begin
               g_res_in[l] = COORD_W'(-q_quo[l][COORD_W-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_res_ff <= g_res_in;
         g_dz_ff  <= g_dz_in;
         g_ovf_ff <= g_ovf_in;
      end
   end

   // Output register and skid register
   logic [RSP_DATA_W-1:0]  skid_data_ff;
   logic [RSP_USER_W-1:0]  skid_user_ff;
   logic                   out_vld_ff;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   logic [RSP_USER_W-1:0]  out_user_ff;
   logic                   out_free;
   logic                   emerge;
   logic [RSP_DATA_W-1:0]  g_data;
   logic [RSP_USER_W-1:0]  g_user;

   assign out_free = ~out_vld_ff | rsp_tready;
   assign emerge   = en & g_vld_ff;
   assign g_data   = {g_res_ff[3], g_res_ff[2], g_res_ff[1], g_res_ff[0]};
   assign g_user   = {g_ovf_ff, g_dz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= emerge;
         end
      end else if (emerge) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_vld_ff) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end else begin
            out_data_ff <= g_data;
            out_user_ff <= g_user;
         end
      end else if (emerge) begin
         skid_data_ff <= g_data;
         skid_user_ff <= g_user;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // A held skid entry always has a result ahead of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_tvalid)
      else $error("skid holds a result with no result at the output");

   // Divide flag only in cartesian mode
   a_dz_cart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> mode_ff == MODE_CART)
      else $error("divide flag raised in homogeneous mode");

   // Divide flag comes with a zero w
   a_dz_w_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[127:96] == '0)
      else $error("divide flag raised with nonzero w");

endmodule
